// ===== rtl/frdb_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame RMS meter package
// Shared types, constants and sequencer states of the frame RMS dB meter.
// ----------------------------------------------------------------------------
package frdb_pkg;

  localparam int unsigned MAX_FRAME = 4096;
  localparam int unsigned SUM_W     = 43;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned DIVD_W    = SUM_W + 2;
  localparam int unsigned REM_W     = CNT_W + 1;
  localparam int unsigned SQ_W      = 34;
  localparam int unsigned LOG_W     = 22;
  localparam int unsigned MANT_W    = 31;
  localparam int unsigned PROD_W    = 43;

  localparam logic signed [18:0] DB_SCALE_K = 19'sd197283;
  localparam logic signed [15:0] SILENT_DB  = -16'sd30720;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [16:0]        rms_level;
    logic signed [15:0] db_level;
    logic               silent;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_NORM,
    ST_SQR,
    ST_SCALE,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/frdb_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one audio sample and its frame flag.
// ----------------------------------------------------------------------------
interface frdb_in_if;
  logic               valid;
  logic               ready;
  frdb_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/frdb_out_if.sv =====
// ----------------------------------------------------------------------------
// Level channel
// Valid/ready channel that carries one frame level result.
// ----------------------------------------------------------------------------
interface frdb_out_if;
  logic                valid;
  logic                ready;
  frdb_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/frame_rms_db_meter_top.sv =====
// ----------------------------------------------------------------------------
// Frame RMS dB meter
// Accumulates squared samples over a frame and reports RMS and dBFS level.
// ----------------------------------------------------------------------------
// Channel  Direction  Beat
// in_i     sink       sample (Q1.15), last
// out_o    source     rms_level (Q1.16), db_level (Q8.8), silent
//
// Samples that do not close a frame are taken one per cycle.
// A closing sample starts the back end when the frame sum is nonzero: a
// restoring divider, a square root, then two logarithms, each of normalising
// shifts and 16 squarings on one shared multiplier, and a scaling step.
// A silent frame skips the back end. The input is held off until the result loads.
// The result register is loaded once it is free; a stalled output holds the
// block in its final state. Reset clears the sum, the count and the sequencer.
// ----------------------------------------------------------------------------
module frame_rms_db_meter_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  frdb_in_if.sink       in_i,
  frdb_out_if.source    out_o
);

  frdb_pkg::state_e state_q, state_d;

  logic [frdb_pkg::SUM_W-1:0]  sum_q, sum_d, sum_s_q, sum_s_d;
  logic [frdb_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_s_q, cnt_s_d;
  logic [frdb_pkg::DIVD_W-1:0] w_q, w_d;
  logic [frdb_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [5:0]                  k_q, k_d;
  logic [frdb_pkg::SQ_W-1:0]   sx_q, sx_d, sr_q, sr_d, sb_q, sb_d;
  logic [frdb_pkg::SUM_W-1:0]  nrm_q, nrm_d;
  logic [5:0]                  nexp_q, nexp_d;
  logic [frdb_pkg::MANT_W-1:0] y_q, y_d;
  logic [15:0]                 frac_q, frac_d;
  logic                        phase_q, phase_d;
  logic [frdb_pkg::LOG_W-1:0]  ls_q, ls_d, lc_q, lc_d;
  logic signed [frdb_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [16:0]                 rms_q, rms_d;
  logic                        sil_q, sil_d;
  logic                        ov_q, ov_d;
  frdb_pkg::out_beat_t         ob_q, ob_d;

  logic                        in_fire, acc_en, close_frame, load_out;
  logic [31:0]                 sq;
  logic [frdb_pkg::SUM_W-1:0]  sum_new;
  logic [frdb_pkg::CNT_W-1:0]  cnt_new;
  logic [frdb_pkg::REM_W:0]    r2;
  logic                        ge;
  logic [frdb_pkg::DIVD_W-1:0] w_nxt;
  logic [frdb_pkg::SQ_W-1:0]   st, sr_nxt;
  logic [61:0]                 p;
  logic [31:0]                 y2;
  logic [15:0]                 frac_nxt;
  logic signed [23:0]          l_s;
  logic signed [frdb_pkg::PROD_W-1:0] v;
  logic signed [18:0]          q;
  logic signed [15:0]          db;

  assign in_fire     = in_i.valid && in_i.ready;
  assign acc_en      = cnt_q < frdb_pkg::CNT_W'(frdb_pkg::MAX_FRAME);
  assign sq          = 32'(in_i.data.sample * in_i.data.sample);
  assign sum_new     = sum_q + (acc_en ? frdb_pkg::SUM_W'(sq) : '0);
  assign cnt_new     = cnt_q + (acc_en ? frdb_pkg::CNT_W'(1) : '0);
  assign close_frame = in_fire && in_i.data.last;
  assign load_out    = (state_q == frdb_pkg::ST_DONE) && (!ov_q || out_o.ready);

  assign r2    = {rem_q, w_q[frdb_pkg::DIVD_W-1]};
  assign ge    = r2 >= (frdb_pkg::REM_W+1)'(cnt_s_q);
  assign w_nxt = {w_q[frdb_pkg::DIVD_W-2:0], ge};

  assign st     = sr_q + sb_q;
  assign sr_nxt = (sx_q >= st) ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);

  assign p        = 62'(y_q) * 62'(y_q);
  assign y2       = p[61:30];
  assign frac_nxt = {frac_q[14:0], y2[31]};

  assign l_s  = $signed(24'(ls_q)) - $signed(24'(lc_q)) - $signed(24'(30 << 16));
  assign v    = prod_q + $signed(frdb_pkg::PROD_W'(1 << 23));
  assign q    = v[frdb_pkg::PROD_W-1:24];

  always_comb begin
    if (q > 19'sd0) begin
      db = 16'sd0;
    end else if (q < -19'sd32768) begin
      db = -16'sd32768;
    end else begin
      db = q[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frdb_pkg::ST_IDLE: begin
        if (close_frame) begin
          state_d = (sum_new == '0) ? frdb_pkg::ST_DONE : frdb_pkg::ST_DIV;
        end
      end
      frdb_pkg::ST_DIV: begin
        if (k_q == 6'(frdb_pkg::DIVD_W - 1)) begin
          state_d = frdb_pkg::ST_SQRT;
        end
      end
      frdb_pkg::ST_SQRT: begin
        if (sb_q[0]) begin
          state_d = frdb_pkg::ST_NORM;
        end
      end
      frdb_pkg::ST_NORM: begin
        if (nrm_q[frdb_pkg::SUM_W-1]) begin
          state_d = frdb_pkg::ST_SQR;
        end
      end
      frdb_pkg::ST_SQR: begin
        if (k_q[3:0] == 4'd15) begin
          state_d = phase_q ? frdb_pkg::ST_SCALE : frdb_pkg::ST_NORM;
        end
      end
      frdb_pkg::ST_SCALE: state_d = frdb_pkg::ST_DONE;
      frdb_pkg::ST_DONE: begin
        if (load_out) begin
          state_d = frdb_pkg::ST_IDLE;
        end
      end
      default: state_d = frdb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    sum_s_d = sum_s_q;
    cnt_s_d = cnt_s_q;
    w_d     = w_q;
    rem_d   = rem_q;
    k_d     = k_q;
    sx_d    = sx_q;
    sr_d    = sr_q;
    sb_d    = sb_q;
    nrm_d   = nrm_q;
    nexp_d  = nexp_q;
    y_d     = y_q;
    frac_d  = frac_q;
    phase_d = phase_q;
    ls_d    = ls_q;
    lc_d    = lc_q;
    prod_d  = prod_q;
    rms_d   = rms_q;
    sil_d   = sil_q;
    ov_d    = ov_q && !out_o.ready;
    ob_d    = ob_q;
    unique case (state_q)
      frdb_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.data.last) begin
            sum_d   = '0;
            cnt_d   = '0;
            sum_s_d = sum_new;
            cnt_s_d = cnt_new;
            w_d     = {sum_new, 2'b00};
            rem_d   = '0;
            k_d     = '0;
            sil_d   = sum_new == '0;
          end else begin
            sum_d = sum_new;
            cnt_d = cnt_new;
          end
        end
      end
      frdb_pkg::ST_DIV: begin
        rem_d = ge ? frdb_pkg::REM_W'(r2 - (frdb_pkg::REM_W+1)'(cnt_s_q))
                   : r2[frdb_pkg::REM_W-1:0];
        w_d   = w_nxt;
        k_d   = k_q + 6'd1;
        sx_d  = frdb_pkg::SQ_W'(w_nxt[32:0]);
        sr_d  = '0;
        sb_d  = frdb_pkg::SQ_W'(64'd1 << 32);
      end
      frdb_pkg::ST_SQRT: begin
        if (sx_q >= st) begin
          sx_d = sx_q - st;
        end
        sr_d  = sr_nxt;
        sb_d  = sb_q >> 2;
        rms_d = sr_nxt[16:0];
        nrm_d = sum_s_q;
        k_d   = '0;
        phase_d = 1'b0;
      end
      frdb_pkg::ST_NORM: begin
        if (nrm_q[frdb_pkg::SUM_W-1]) begin
          y_d    = nrm_q[frdb_pkg::SUM_W-1 -: frdb_pkg::MANT_W];
          nexp_d = 6'(frdb_pkg::SUM_W - 1) - k_q;
          frac_d = '0;
          k_d    = '0;
        end else begin
          nrm_d = nrm_q << 1;
          k_d   = k_q + 6'd1;
        end
      end
      frdb_pkg::ST_SQR: begin
        y_d    = y2[31] ? y2[31:1] : y2[30:0];
        frac_d = frac_nxt;
        k_d    = k_q + 6'd1;
        if (k_q[3:0] == 4'd15) begin
          k_d = '0;
          if (phase_q) begin
            lc_d = {nexp_q, frac_nxt};
          end else begin
            ls_d    = {nexp_q, frac_nxt};
            nrm_d   = frdb_pkg::SUM_W'(cnt_s_q);
            phase_d = 1'b1;
          end
        end
      end
      frdb_pkg::ST_SCALE: begin
        prod_d = frdb_pkg::PROD_W'(l_s) * frdb_pkg::PROD_W'(frdb_pkg::DB_SCALE_K);
      end
      frdb_pkg::ST_DONE: begin
        if (load_out) begin
          ov_d = 1'b1;
          ob_d.silent = sil_q;
          if (sil_q) begin
            ob_d.rms_level = '0;
            ob_d.db_level  = frdb_pkg::SILENT_DB;
          end else begin
            ob_d.rms_level = rms_q;
            ob_d.db_level  = db;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_i.ready  = state_q == frdb_pkg::ST_IDLE;
    out_o.valid = ov_q;
    out_o.data  = ob_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frdb_pkg::ST_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      k_q     <= '0;
      phase_q <= 1'b0;
      sil_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      k_q     <= k_d;
      phase_q <= phase_d;
      sil_q   <= sil_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_s_q <= sum_s_d;
    cnt_s_q <= cnt_s_d;
    w_q     <= w_d;
    rem_q   <= rem_d;
    sx_q    <= sx_d;
    sr_q    <= sr_d;
    sb_q    <= sb_d;
    nrm_q   <= nrm_d;
    nexp_q  <= nexp_d;
    y_q     <= y_d;
    frac_q  <= frac_d;
    ls_q    <= ls_d;
    lc_q    <= lc_d;
    prod_q  <= prod_d;
    rms_q   <= rms_d;
    ob_q    <= ob_d;
  end

endmodule

// ===== tb/frame_rms_db_meter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame RMS dB meter testbench
// Drives sample frames with random gaps and output stalls, predicts the RMS
// and dBFS level of every closed frame and checks each result beat in order.
// ----------------------------------------------------------------------------
module frame_rms_db_meter_top_test;

  logic clk_i;
  logic rst_ni;

  frdb_in_if  in_i ();
  frdb_out_if out_o ();

  frame_rms_db_meter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i.sink),
    .out_o  (out_o.source)
  );

  frdb_pkg::out_beat_t level_q[$];
  logic [63:0] acc_sum;
  int unsigned acc_cnt;
  int          errors;
  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("frame_rms_db_meter_top_test failed");
    $finish;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint log2_fix(logic [63:0] x);
    int          n;
    logic [63:0] y;
    longint      frac;
    frac = 0;
    n = 63;
    if (x == 0) return 0;
    while (x[n] == 1'b0) n--;
    if (n > 30) y = x >> (n - 30);
    else y = x << (30 - n);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    return (longint'(n) << 16) + frac;
  endfunction

  task automatic accumulate(logic signed [15:0] s, logic l);
    longint              v;
    longint              q;
    frdb_pkg::out_beat_t r;
    if (acc_cnt < frdb_pkg::MAX_FRAME) begin
      acc_sum = acc_sum + 64'(longint'(s) * longint'(s));
      acc_cnt++;
    end
    if (l) begin
      r.rms_level = '0;
      r.db_level  = frdb_pkg::SILENT_DB;
      r.silent    = 1'b1;
      if (acc_sum != 0 && acc_cnt != 0) begin
        r.rms_level = 17'(isqrt64((acc_sum * 4) / 64'(acc_cnt)));
        v = (log2_fix(acc_sum) - log2_fix(64'(acc_cnt)) - (longint'(30) << 16)) * 197283
            + (longint'(1) << 23);
        q = v >>> 24;
        if (q > 0) q = 0;
        if (q < -32768) q = -32768;
        r.db_level = 16'(q);
        r.silent   = 1'b0;
      end
      level_q.push_back(r);
      acc_sum = 0;
      acc_cnt = 0;
    end
  endtask

  task automatic send_sample(logic signed [15:0] s, logic l);
    while ($urandom_range(99) < tx_idle) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid       <= 1'b1;
    in_i.data.sample <= s;
    in_i.data.last   <= l;
    do @(posedge clk_i); while (!in_i.ready);
    accumulate(s, l);
  endtask

  task automatic pause_until_drained();
    in_i.valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(5))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'(int'($urandom_range(6)) - 3);
      3:       return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh2AAB, 1'b0);
    send_sample(16'sd3, 1'b1);
    pause_until_drained();
  endtask

  task automatic test_frame_overflow();
    for (int i = 0; i < frdb_pkg::MAX_FRAME + 4; i++)
      send_sample((i < frdb_pkg::MAX_FRAME) ? 16'sh8000 : 16'sd7,
                  i == frdb_pkg::MAX_FRAME + 3);
    pause_until_drained();
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned len;
    int unsigned sent;
    logic        zero_frame;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(300, 1) : $urandom_range(24, 1);
      zero_frame = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++)
        send_sample(zero_frame ? 16'sd0 : rand_sample(), i == len - 1);
      sent += len;
    end
  endtask

  task automatic test_output_stall();
    hold_left = 2000;
    for (int f = 0; f < 20; f++)
      for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 3);
    pause_until_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_o.ready <= 1'b0;
    end else begin
      out_o.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    frdb_pkg::out_beat_t e;
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (level_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = level_q.pop_front();
        if (out_o.data.rms_level !== e.rms_level) begin
          $error("rms_level expected %0d actual %0d", e.rms_level, out_o.data.rms_level);
          errors++;
        end
        if (out_o.data.db_level !== e.db_level) begin
          $error("db_level expected %0d actual %0d", e.db_level, out_o.data.db_level);
          errors++;
        end
        if (out_o.data.silent !== e.silent) begin
          $error("silent expected %0d actual %0d", e.silent, out_o.data.silent);
          errors++;
        end
      end
    end
  end

  initial begin
    errors      = 0;
    acc_sum     = 0;
    acc_cnt     = 0;
    hold_left   = 0;
    tx_idle     = 0;
    rx_idle     = 0;
    rst_ni      = 1'b0;
    in_i.valid  = 1'b0;
    in_i.data   = '0;
    out_o.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_frame_overflow();
    tx_idle = 15;
    rx_idle = 72;
    test_random(650);
    tx_idle = 72;
    rx_idle = 15;
    test_random(650);
    tx_idle = 0;
    rx_idle = 0;
    test_random(650);
    test_output_stall();
    if (level_q.size() != 0) begin
      $error("results still expected at end of run");
      errors++;
    end
    if (errors == 0) begin
      $display("frame_rms_db_meter_top_test passed");
    end else begin
      $display("frame_rms_db_meter_top_test failed");
    end
    $finish;
  end
endmodule
